[design/sirt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_pkg: shared types and constants for the signed integer to text block
// Holds the transaction structs, the radix codes, the digit count constants
// and the ASCII helpers used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package sirt_pkg;

   // Width of the signed input value.
   localparam int VALUE_WIDTH = 32;
   // Magnitude bits that can be nonzero after sign handling.
   localparam int MAG_WIDTH   = VALUE_WIDTH - 1;

   // Digit counts for each radix, wide enough for any magnitude.
   localparam int N_BIN = MAG_WIDTH;
   localparam int N_OCT = (MAG_WIDTH + 2) / 3;
   localparam int N_HEX = (MAG_WIDTH + 3) / 4;
   localparam int N_DEC = (VALUE_WIDTH * 30103) / 100000 + 1;

   // Width of the BCD register used by the decimal conversion.
   localparam int BCD_WIDTH = 4 * N_DEC;

   // The digit shifter holds the widest top-aligned digit string.
   localparam int DIG_A     = (MAG_WIDTH > 3 * N_OCT) ? MAG_WIDTH : 3 * N_OCT;
   localparam int DIG_B     = (4 * N_HEX > BCD_WIDTH) ? 4 * N_HEX : BCD_WIDTH;
   localparam int DIG_WIDTH = (DIG_A > DIG_B) ? DIG_A : DIG_B;

   // Digit count register width; binary always has the most digits.
   localparam int CNT_WIDTH = $clog2(N_BIN + 1);

   // Command codes on the request channel.
   localparam logic [2:0] CMD_BIN = 3'd0;
   localparam logic [2:0] CMD_OCT = 3'd1;
   localparam logic [2:0] CMD_DEC = 3'd2;
   localparam logic [2:0] CMD_HEX = 3'd3;

   // ASCII characters used in the text.
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // Radix as carried in the queue.
   typedef enum logic [1:0] {
      RADIX_BIN = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_DEC = 2'd2,
      RADIX_HEX = 2'd3
   } radix_type;

   // Request transaction.
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [2:0]                    cmd;
   } req_type;

   // Result transaction, one character.
   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
      logic       ok;
   } rsp_type;

   // Classified item passed from the front end to the back end.
   typedef struct packed {
      radix_type              radix;
      logic                   neg;
      logic                   bad;
      logic                   no_digits;
      logic [MAG_WIDTH-1:0]   mag;
   } desc_type;

   // Queue status seen by both ends.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // ASCII character of one digit, uppercase for values above nine.
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] wide;
      wide = {4'b0000, d};
      if (d > 4'd9) begin
         digit_char = CHAR_A + wide - 8'd10;
      end else begin
         digit_char = CHAR_0 + wide;
      end
   endfunction

endpackage

[design/signed_int_to_radix_text_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_radix_text_core: signed integer to ASCII text in four radices
// Converts a signed value to sign plus digits in binary, octal, decimal or
// hex, one character per result.
//
//   Channel   Ports                      Handshake
//   request   start, busy, req_payload   taken when start and not busy
//   result    rsp_strobe, rsp_payload    valid for one cycle, no back pressure
//
// The front end classifies a request in the cycle it is taken and writes it
// into a queue of QUEUE_DEPTH items; busy is high only while that queue is full.
// The back end emits the sign character, then the digits one per cycle, most
// significant first; a decimal item first passes through a one-bit-per-cycle BCD
// conversion and a handoff to the digit shifter ahead of the digits.
// Reset is synchronous and clears the queue and the sequencer.
// ----------------------------------------------------------------------------
module signed_int_to_radix_text_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sirt_pkg::req_type  req_payload,
   output logic               rsp_strobe,
   output sirt_pkg::rsp_type  rsp_payload
);

   sirt_pkg::q_status_type q_status;
   sirt_pkg::desc_type     q_push_data;
   sirt_pkg::desc_type     q_head;
   logic                   q_push;
   logic                   q_pop;

   // Request intake and classification.
   sirt_front u_front (
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_data      (q_push_data)
   );

   // Queue between the two ends.
   sirt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   // Digit generation and output.
   sirt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_status    (q_status),
      .q_pop       (q_pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

[design/sirt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_front: request intake and classification
// Accepts a request while the queue has room, takes the magnitude and sign,
// decodes the radix and flags the cases that produce no digits.
// ----------------------------------------------------------------------------
module sirt_front (
   input  logic                  start,
   output logic                  busy,
   input  sirt_pkg::req_type     req_payload,
   input  sirt_pkg::q_status_type q_status,
   output logic                  q_push,
   output sirt_pkg::desc_type    q_data
);

   logic [sirt_pkg::VALUE_WIDTH-1:0] neg_value;
   logic                             neg;
   logic                             bad;
   logic                             mag_zero;
   sirt_pkg::radix_type              radix;

   // The queue being full is the only back pressure.
   assign busy   = q_status.full;
   assign q_push = start && !q_status.full;

   // Sign and magnitude; the most negative value wraps to a zero magnitude.
   assign neg       = req_payload.value[sirt_pkg::VALUE_WIDTH-1];
   assign neg_value = -req_payload.value;

   // Radix decode; codes above hex are unrecognized.
   always_comb begin
      bad   = 1'b0;
      radix = sirt_pkg::RADIX_BIN;
      unique case (req_payload.cmd)
         sirt_pkg::CMD_BIN: radix = sirt_pkg::RADIX_BIN;
         sirt_pkg::CMD_OCT: radix = sirt_pkg::RADIX_OCT;
         sirt_pkg::CMD_DEC: radix = sirt_pkg::RADIX_DEC;
         sirt_pkg::CMD_HEX: radix = sirt_pkg::RADIX_HEX;
         default:           bad   = 1'b1;
      endcase
   end

   // Build the descriptor pushed into the queue.
   always_comb begin
      q_data.radix = radix;
      q_data.neg   = neg;
      q_data.bad   = bad;
      q_data.mag   = neg ? neg_value[sirt_pkg::MAG_WIDTH-1:0]
                         : req_payload.value[sirt_pkg::MAG_WIDTH-1:0];
      // A negative value with zero magnitude is the most negative value.
      q_data.no_digits = bad || (neg && mag_zero && (radix != sirt_pkg::RADIX_BIN));
   end

   assign mag_zero = (neg_value[sirt_pkg::MAG_WIDTH-1:0] == '0);

endmodule

[design/sirt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_queue: short queue between front end and back end
// A small circular buffer of classified items with full and empty status.
// ----------------------------------------------------------------------------
module sirt_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sirt_pkg::desc_type     push_data,
   input  logic                   pop,
   output sirt_pkg::desc_type     head,
   output sirt_pkg::q_status_type status
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   sirt_pkg::desc_type    entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == CNT_WIDTH'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The front end never writes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("queue written while full");

   // The back end never takes from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("queue read while empty");

   // A write without a read leaves at least one item behind.
   a_push_holds: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !status.empty)
      else $error("queue lost an item");

endmodule

[design/sirt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_back: digit generation and character output
// Takes one classified item at a time, emits the sign or NUL for a bad radix, converts
// decimal values to BCD one bit per cycle, skips leading zeros except in binary and
// emits one digit per cycle, most significant first, through a registered output.
// ----------------------------------------------------------------------------
module sirt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sirt_pkg::desc_type     q_head,
   input  sirt_pkg::q_status_type q_status,
   output logic                   q_pop,
   output logic                   rsp_strobe,
   output sirt_pkg::rsp_type      rsp_payload
);

   localparam int MW  = sirt_pkg::MAG_WIDTH;
   localparam int DW  = sirt_pkg::DIG_WIDTH;
   localparam int BW  = sirt_pkg::BCD_WIDTH;
   localparam int CW  = sirt_pkg::CNT_WIDTH;
   localparam int PAD = DW - MW;

   typedef enum logic [3:0] {
      B_IDLE  = 4'b0001,
      B_CONV  = 4'b0010,
      B_SKIP  = 4'b0100,
      B_DIGIT = 4'b1000
   } back_state_type;

   back_state_type       state_ff, state_in;
   sirt_pkg::radix_type  radix_ff, radix_in;
   logic [MW-1:0]        mag_ff, mag_in;
   logic [BW-1:0]        bcd_ff, bcd_in;
   logic [DW-1:0]        dig_ff, dig_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   sirt_pkg::rsp_type    rsp_ff, rsp_in;

   logic [BW-1:0]        bcd_adj;
   logic [DW-1:0]        mag_wide;
   logic [3:0]           top_digit;
   logic [DW-1:0]        dig_shift;

   // Add-three correction on every BCD digit before the shift.
   always_comb begin
      for (int i = 0; i < sirt_pkg::N_DEC; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                       : bcd_ff[i*4 +: 4];
      end
   end

   assign mag_wide = {{PAD{1'b0}}, q_head.mag};

   // Leading digit and the shift that drops it, by radix.
   always_comb begin
      unique case (radix_ff)
         sirt_pkg::RADIX_BIN: begin
            top_digit = {3'b000, dig_ff[DW-1]};
            dig_shift = dig_ff << 1;
         end
         sirt_pkg::RADIX_OCT: begin
            top_digit = {1'b0, dig_ff[DW-1 -: 3]};
            dig_shift = dig_ff << 3;
         end
         default: begin
            top_digit = dig_ff[DW-1 -: 4];
            dig_shift = dig_ff << 4;
         end
      endcase
   end

   // Sequencer for one item.
   always_comb begin
      state_in      = state_ff;
      radix_in      = radix_ff;
      mag_in        = mag_ff;
      bcd_in        = bcd_ff;
      dig_in        = dig_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      q_pop         = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               // Take the next item and emit its sign character, or NUL for a bad radix.
               q_pop           = 1'b1;
               rsp_strobe_in   = 1'b1;
               rsp_in.out_char = q_head.bad ? sirt_pkg::CHAR_NUL :
                                 q_head.neg ? sirt_pkg::CHAR_MINUS : sirt_pkg::CHAR_PLUS;
               rsp_in.last     = q_head.no_digits;
               rsp_in.ok       = !q_head.bad;
               radix_in        = q_head.radix;
               mag_in          = q_head.mag;
               bcd_in          = '0;
               if (q_head.no_digits) begin
                  state_in = B_IDLE;
               end else begin
                  unique case (q_head.radix)
                     sirt_pkg::RADIX_BIN: begin
                        dig_in   = mag_wide << PAD;
                        cnt_in   = CW'(sirt_pkg::N_BIN);
                        state_in = B_DIGIT;
                     end
                     sirt_pkg::RADIX_OCT: begin
                        dig_in   = mag_wide << (DW - 3 * sirt_pkg::N_OCT);
                        cnt_in   = CW'(sirt_pkg::N_OCT);
                        state_in = B_SKIP;
                     end
                     sirt_pkg::RADIX_DEC: begin
                        cnt_in   = CW'(MW);
                        state_in = B_CONV;
                     end
                     default: begin
                        dig_in   = mag_wide << (DW - 4 * sirt_pkg::N_HEX);
                        cnt_in   = CW'(sirt_pkg::N_HEX);
                        state_in = B_SKIP;
                     end
                  endcase
               end
            end
         end
         B_CONV: begin
            // Shift one magnitude bit per cycle into the BCD register.
            if (cnt_ff == '0) begin
               dig_in   = DW'(bcd_ff) << (DW - BW);
               cnt_in   = CW'(sirt_pkg::N_DEC);
               state_in = B_SKIP;
            end else begin
               bcd_in = {bcd_adj[BW-2:0], mag_ff[MW-1]};
               mag_in = mag_ff << 1;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         B_SKIP: begin
            // Drop leading zeros but keep at least one digit.
            if ((top_digit == 4'd0) && (cnt_ff > CW'(1))) begin
               dig_in = dig_shift;
               cnt_in = cnt_ff - 1'b1;
            end else begin
               state_in = B_DIGIT;
            end
         end
         B_DIGIT: begin
            rsp_strobe_in   = 1'b1;
            rsp_in.out_char = sirt_pkg::digit_char(top_digit);
            rsp_in.last     = (cnt_ff == CW'(1));
            rsp_in.ok       = 1'b1;
            dig_in          = dig_shift;
            cnt_in          = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      radix_ff <= radix_in;
      mag_ff   <= mag_in;
      bcd_ff   <= bcd_in;
      dig_ff   <= dig_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // An unrecognized radix yields exactly one NUL character marked last.
   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_ff.ok) |-> (rsp_ff.last && (rsp_ff.out_char == '0)))
      else $error("unrecognized radix result malformed");

   // Digit output always has a digit left to send.
   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIGIT) |-> (cnt_ff != '0))
      else $error("digit state with no digits left");

   // A finished conversion moves on to leading zero removal.
   a_conv_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == B_CONV) && (cnt_ff == '0)) |=> (state_ff == B_SKIP))
      else $error("decimal conversion did not finish");

endmodule

[tb/signed_int_to_radix_text_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_radix_text_core_test: self-checking bench for the text core
// A driver feeds conversion requests from a queue, and a monitor predicts the
// characters of every accepted request and checks each result strobe against
// them in order. The run covers directed corner values, then random values in
// every radix under several sender idling patterns.
// ----------------------------------------------------------------------------
module signed_int_to_radix_text_core_test;

   localparam int VW = sirt_pkg::VALUE_WIDTH;
   // Highest code the command field can carry; codes above hex are unknown.
   localparam logic [2:0] CMD_TOP = 3'd7;
   // Random conversions per idling phase.
   localparam int PHASE_ITEMS = 160;
   // Cycles allowed after the last expected character has arrived.
   localparam int TAIL_CYCLES = 60;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   sirt_pkg::req_type req_payload = '0;
   logic              rsp_strobe;
   sirt_pkg::rsp_type rsp_payload;

   // Requests waiting to be driven, and characters still owed by the core.
   sirt_pkg::req_type pending_items[$];
   sirt_pkg::rsp_type expected_chars[$];

   int idle_pct = 0;
   int error_count = 0;
   int char_count = 0;
   int radix_items[5];

   signed_int_to_radix_text_core DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // Free-running clock, 10 ns period.
   always #5 clock = ~clock;

   // Works out the text of one request and appends its characters.
   function automatic void predict_text(input sirt_pkg::req_type item);
      logic [VW-1:0]     raw;
      logic [VW-1:0]     mag;
      logic [VW-1:0]     base;
      logic [VW-1:0]     digit;
      logic              neg;
      logic [7:0]        text[$];
      sirt_pkg::rsp_type chr;
      if (item.cmd > sirt_pkg::CMD_HEX) begin
         radix_items[4]++;
         chr.out_char = sirt_pkg::CHAR_NUL;
         chr.last     = 1'b1;
         chr.ok       = 1'b0;
         expected_chars.push_back(chr);
         return;
      end
      radix_items[item.cmd]++;
      raw  = item.value;
      neg  = raw[VW-1];
      mag  = neg ? -raw : raw;
      if (item.cmd == sirt_pkg::CMD_BIN) begin
         // Binary always shows every magnitude bit below the sign.
         for (int i = VW - 2; i >= 0; i--) begin
            text.push_back(sirt_pkg::CHAR_0 + {7'd0, mag[i]});
         end
      end else if (raw == '0) begin
         text.push_back(sirt_pkg::CHAR_0);
      end else if (!(neg && mag[VW-1])) begin
         // The most negative value wraps on negation and shows no digits.
         case (item.cmd)
            sirt_pkg::CMD_OCT: base = 8;
            sirt_pkg::CMD_DEC: base = 10;
            default:           base = 16;
         endcase
         while (mag != '0) begin
            digit = mag % base;
            mag   = mag / base;
            if (digit < 10) begin
               text.push_front(sirt_pkg::CHAR_0 + digit[7:0]);
            end else begin
               text.push_front(sirt_pkg::CHAR_A + digit[7:0] - 8'd10);
            end
         end
      end
      text.push_front(neg ? sirt_pkg::CHAR_MINUS : sirt_pkg::CHAR_PLUS);
      foreach (text[k]) begin
         chr.out_char = text[k];
         chr.last     = (k == text.size() - 1);
         chr.ok       = 1'b1;
         expected_chars.push_back(chr);
      end
   endfunction

   // Reports one field that differs from its expectation.
   task automatic report_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 50) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         end
      end
   endtask

   // Driver: presents the oldest pending request, holding it while busy.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            void'(pending_items.pop_front());
         end
         if (!(start && busy)) begin
            if (pending_items.size() == 0 || $urandom_range(0, 99) < idle_pct) begin
               start <= 1'b0;
            end else begin
               start       <= 1'b1;
               req_payload <= pending_items[0];
            end
         end
      end
   end

   // Monitor: predicts each accepted transaction, then checks any result.
   always @(posedge clock) begin
      sirt_pkg::rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            predict_text(req_payload);
         end
         if (rsp_strobe) begin
            char_count++;
            if (expected_chars.size() == 0) begin
               error_count++;
               if (error_count <= 50) begin
                  $display("%0t: unexpected character, expected none, actual %h last %b ok %b",
                           $time, rsp_payload.out_char, rsp_payload.last, rsp_payload.ok);
               end
            end else begin
               want = expected_chars.pop_front();
               report_field("out_char", want.out_char, rsp_payload.out_char);
               report_field("last", {7'd0, want.last}, {7'd0, rsp_payload.last});
               report_field("ok", {7'd0, want.ok}, {7'd0, rsp_payload.ok});
            end
         end
      end
   end

   task automatic queue_item(input logic [VW-1:0] value, input logic [2:0] cmd);
      sirt_pkg::req_type item;
      item.value = value;
      item.cmd   = cmd;
      pending_items.push_back(item);
   endtask

   // Waits until every request has been taken and every character has come.
   task automatic wait_for_drain;
      while (pending_items.size() != 0 || expected_chars.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Random value, weighted toward corners, small numbers and single bits.
   function automatic logic [VW-1:0] pick_value;
      logic [VW-1:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: v = '0;
               1: v = 1;
               2: v = '1;
               3: v = {1'b0, {(VW-1){1'b1}}};
               4: v = {1'b1, {(VW-1){1'b0}}};
               default: v = {1'b1, {(VW-2){1'b0}}, 1'b1};
            endcase
         end
         1, 2: v = $urandom_range(0, 40) - 20;
         3: begin
            v = 1 << $urandom_range(0, VW - 1);
            if ($urandom_range(0, 1)) begin
               v = -v;
            end
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Stimulus: directed corners, then random phases with different idling.
   initial begin
      logic [2:0] cmd;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Zero, the extremes and minus one in every recognized radix.
      for (int c = sirt_pkg::CMD_BIN; c <= sirt_pkg::CMD_HEX; c++) begin
         queue_item('0, 3'(c));
         queue_item({1'b1, {(VW-1){1'b0}}}, 3'(c));
         queue_item({1'b0, {(VW-1){1'b1}}}, 3'(c));
         queue_item('1, 3'(c));
      end
      // Hex letters in both signs, every decimal digit, a lone one, alternating bits.
      queue_item(32'h7ABC_DEF0, sirt_pkg::CMD_HEX);
      queue_item(-32'sh0FED_CBA9, sirt_pkg::CMD_HEX);
      queue_item(-32'sd1234567890, sirt_pkg::CMD_DEC);
      queue_item(32'd1, sirt_pkg::CMD_OCT);
      queue_item(32'h5555_5555, sirt_pkg::CMD_BIN);
      // Every unknown radix code.
      for (int c = sirt_pkg::CMD_HEX + 1; c <= CMD_TOP; c++) begin
         queue_item($urandom, 3'(c));
      end
      wait_for_drain();

      // Each phase ends with the sender paused until all text has arrived.
      for (int p = 0; p < 3; p++) begin
         idle_pct = (p == 1) ? 64 : (p == 2) ? 34 : 0;
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 12) begin
               cmd = 3'($urandom_range(sirt_pkg::CMD_HEX + 1, CMD_TOP));
            end else begin
               cmd = 3'($urandom_range(sirt_pkg::CMD_BIN, sirt_pkg::CMD_HEX));
            end
            queue_item(pick_value(), cmd);
         end
         wait_for_drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Converted %0d binary, %0d octal, %0d decimal, %0d hex, %0d unknown-radix values,",
               radix_items[0], radix_items[1], radix_items[2], radix_items[3], radix_items[4]);
      $display("checking %0d characters with %0d errors.", char_count, error_count);
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("signed_int_to_radix_text_core_test: done, clean");
      end else begin
         $display("signed_int_to_radix_text_core_test: done, errors");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #4_000_000;
      $display("Timeout with %0d characters still expected.", expected_chars.size());
      $display("signed_int_to_radix_text_core_test: done, errors");
      $finish;
   end

endmodule

[signed_int_to_radix_text_core.f]
design/sirt_pkg.sv
design/sirt_front.sv
design/sirt_queue.sv
design/sirt_back.sv
design/signed_int_to_radix_text_core.sv
tb/signed_int_to_radix_text_core_test.sv
